// File: sv/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

    // Field widths
    localparam int BASE_W = 31;
    localparam int EXP_W  = 31;
    localparam int RES_W  = 30;

    // Default number of exponent bits examined
    localparam int EXP_BITS_DEF = 31;

    // Stream bus widths (fields rounded up to whole bytes)
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;

    // Modulus and Barrett constant floor(2^60 / P)
    localparam logic [RES_W-1:0] PRIME_MOD = 30'd1000000007;
    localparam logic [63:0] MU_WIDE = (64'd1 << 60) / 64'(PRIME_MOD);
    localparam logic [30:0] BARRETT_MU = MU_WIDE[30:0];

    // Request into the shared multiply-reduce unit
    typedef struct packed {
        logic             start;
        logic [RES_W-1:0] a;
        logic [RES_W-1:0] b;
    } mm_req_t;

    // One compare-and-subtract step of the modulus
    function automatic logic [31:0] cond_sub(input logic [31:0] v);
        logic [31:0] p;
        p = {2'b00, PRIME_MOD};
        return (v >= p) ? (v - p) : v;
    endfunction

endpackage

`default_nettype wire

// File: sv/mexp_mulmod.sv
`default_nettype none

// Multi-cycle a*b mod P with one 31x31 multiplier reused three times:
// product, Barrett quotient estimate, quotient times modulus. Two
// compare-subtract steps then close the Barrett error. Done is asserted
// in state S_FIX2, reached from the start through S_EST, S_QP, S_SUB and S_FIX1.
module mexp_mulmod (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mexp_pkg::mm_req_t        req,
    output logic                          done,
    output logic [mexp_pkg::RES_W-1:0]    result
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EST,
        S_QP,
        S_SUB,
        S_FIX1,
        S_FIX2
    } mm_state_t;

    mm_state_t   state_reg;
    logic [59:0] prod_reg;
    logic [61:0] mul_reg;
    logic [31:0] rem_reg;

    logic [30:0] op_a;
    logic [30:0] op_b;
    logic [61:0] mul_full;
    logic [31:0] rem_fix;

    // Operand select for the shared multiplier
    always_comb
    begin
        case (state_reg)
            S_EST:
            begin
                op_a = prod_reg[59:29];
                op_b = BARRETT_MU;
            end
            S_QP:
            begin
                op_a = mul_reg[61:31];
                op_b = {1'b0, PRIME_MOD};
            end
            default:
            begin
                op_a = {1'b0, req.a};
                op_b = {1'b0, req.b};
            end
        endcase
    end

    assign mul_full = op_a * op_b;
    assign rem_fix  = cond_sub(rem_reg);

    assign done   = (state_reg == S_FIX2);
    assign result = rem_fix[RES_W-1:0];

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        prod_reg  <= mul_full[59:0];
                        state_reg <= S_EST;
                    end
                end
                S_EST:
                begin
                    mul_reg   <= mul_full;
                    state_reg <= S_QP;
                end
                S_QP:
                begin
                    mul_reg   <= mul_full;
                    state_reg <= S_SUB;
                end
                S_SUB:
                begin
                    // remainder is below 3P, so the low 32 bits are exact
                    rem_reg   <= prod_reg[31:0] - mul_reg[31:0];
                    state_reg <= S_FIX1;
                end
                S_FIX1:
                begin
                    rem_reg   <= rem_fix;
                    state_reg <= S_FIX2;
                end
                S_FIX2:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/modular_exponentiation_unit.sv
`default_nettype none

// Computes base^exponent mod 1000000007 by right-to-left square and
// multiply on one shared multiply-reduce unit (a single 31x31 multiplier
// with Barrett reduction). One transaction is worked on at a time;
// s_tready is high only while the sequencer is idle. The time an item
// takes grows with the position of the highest set exponent bit and with
// the number of set bits; a zero exponent needs no modular product.
// Only the low min(EXP_BITS, EXP_W) exponent bits take part. The result
// sits in an output register, so a new transaction is taken while it waits.
module modular_exponentiation_unit #(
    parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [mexp_pkg::S_TDATA_W-1:0] s_tdata,  // base_value[30:0], exponent[61:31]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [mexp_pkg::M_TDATA_W-1:0]      m_tdata   // power_mod[29:0]
);
    import mexp_pkg::*;

    localparam int ROUNDS = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED1,
        ST_RED2,
        ST_ROUND,
        ST_MUL,
        ST_SQ_GO,
        ST_SQR,
        ST_FINISH
    } top_state_t;

    top_state_t        state_reg;
    logic [BASE_W-1:0] base_reg;
    logic [ROUNDS-1:0] exp_reg;
    logic [RES_W-1:0]  acc_reg;
    logic [RES_W-1:0]  power_reg;
    logic [RES_W-1:0]  out_reg;
    logic              out_valid_reg;

    mm_req_t           mm_req;
    logic              mm_done;
    logic [RES_W-1:0]  mm_result;
    logic [31:0]       base_fix;
    logic              out_free;

    mexp_mulmod u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mm_req),
        .done   (mm_done),
        .result (mm_result)
    );

    // Requests to the shared unit: multiply on a set bit (the square follows from ST_SQ_GO), square on a clear bit
    always_comb
    begin
        mm_req.start = 1'b0;
        mm_req.a     = power_reg;
        mm_req.b     = power_reg;
        case (state_reg)
            ST_ROUND:
            begin
                if (exp_reg != '0)
                begin
                    mm_req.start = 1'b1;
                    if (exp_reg[0])
                    begin
                        mm_req.a = acc_reg;
                    end
                end
            end
            ST_SQ_GO:
            begin
                mm_req.start = 1'b1;
            end
            default:
            begin
                mm_req.start = 1'b0;
            end
        endcase
    end

    assign base_fix = cond_sub({1'b0, base_reg});
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, out_reg};

    // Exponent sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a finishing item reloads the output register instead
            if (out_valid_reg && m_tready && state_reg != ST_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        base_reg  <= s_tdata[BASE_W-1:0];
                        exp_reg   <= s_tdata[BASE_W +: ROUNDS];
                        acc_reg   <= RES_W'(1);
                        state_reg <= ST_RED1;
                    end
                end
                ST_RED1:
                begin
                    base_reg  <= base_fix[BASE_W-1:0];
                    state_reg <= ST_RED2;
                end
                ST_RED2:
                begin
                    power_reg <= base_fix[RES_W-1:0];
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    // no set bits left: further squaring changes nothing
                    if (exp_reg == '0)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else if (exp_reg[0])
                    begin
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        state_reg <= ST_SQR;
                    end
                end
                ST_MUL:
                begin
                    if (mm_done)
                    begin
                        acc_reg   <= mm_result;
                        state_reg <= ST_SQ_GO;
                    end
                end
                ST_SQ_GO:
                begin
                    state_reg <= ST_SQR;
                end
                ST_SQR:
                begin
                    if (mm_done)
                    begin
                        power_reg <= mm_result;
                        exp_reg   <= exp_reg >> 1;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_reg       <= acc_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mm_done |-> (state_reg == ST_MUL || state_reg == ST_SQR))
        else $error("multiply-reduce done outside a wait state");

    a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (acc_reg < PRIME_MOD && power_reg < PRIME_MOD))
        else $error("operand not reduced modulo the prime");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[RES_W-1:0] < PRIME_MOD))
        else $error("result out of range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again right after a transaction");

endmodule

`default_nettype wire
